// File: sv/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: sv/fqow_pkg.sv
// Types and constants shared by the queue with ordered waiters.
package fqow_pkg;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned REQ_W     = 4;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned STATUS_W  = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_TRY = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DELIVERED = 3'd0,
    ST_STORED    = 3'd1,
    ST_WAITING   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ITEM_OVF  = 3'd4,
    ST_WAIT_OVF  = 3'd5
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic latch;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
    logic items_pend;
    logic waiters_pend;
  } sts_t;

endpackage

// File: sv/fqow_if.sv
// Request and response channel interfaces of the queue.
interface fqow_req_if;
  logic                             valid;
  logic                             ready;
  logic [fqow_pkg::KIND_W-1:0]      kind;
  logic [fqow_pkg::REQ_W-1:0]       requester;
  logic [fqow_pkg::PAYLOAD_W-1:0]   item_data;

  modport source (output valid, output kind, output requester, output item_data,
                  input ready);
  modport sink   (input valid, input kind, input requester, input item_data,
                  output ready);
endinterface

interface fqow_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fqow_pkg::STATUS_W-1:0]    status;
  logic [fqow_pkg::REQ_W-1:0]       recipient;
  logic [fqow_pkg::PAYLOAD_W-1:0]   out_data;
  logic [fqow_pkg::PAYLOAD_W-1:0]   visit_total;

  modport source (output valid, output status, output recipient, output out_data,
                  output visit_total, input ready);
  modport sink   (input valid, input status, input recipient, input out_data,
                  input visit_total, output ready);
endinterface

// File: sv/fqow_ctrl.sv
// Controller state machine: takes one request beat, then runs it once the output is free.
module fqow_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fqow_pkg::sts_t  sts_i,
  output fqow_pkg::cmd_t  cmd_o
);

  fqow_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqow_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fqow_pkg::S_IDLE: begin
        if (in_valid_i) state_d = fqow_pkg::S_EXEC;
      end
      fqow_pkg::S_EXEC: begin
        if (!sts_i.out_blocked) state_d = fqow_pkg::S_IDLE;
      end
      default: state_d = fqow_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.latch = 1'b0;
    cmd_o.exec  = 1'b0;
    case (state_q)
      fqow_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      fqow_pkg::S_EXEC: begin
        cmd_o.exec = !sts_i.out_blocked;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/fqow_dp.sv
// Datapath: item and waiter ring buffers, visit counter and the output register.
module fqow_dp #(
  parameter int unsigned ITEM_DEPTH   = 16,
  parameter int unsigned WAITER_DEPTH = 16,
  parameter int unsigned DATA_WIDTH   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fqow_pkg::cmd_t                   cmd_i,
  output fqow_pkg::sts_t                   sts_o,
  input  logic [fqow_pkg::KIND_W-1:0]      kind_i,
  input  logic [fqow_pkg::REQ_W-1:0]       requester_i,
  input  logic [fqow_pkg::PAYLOAD_W-1:0]   item_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fqow_pkg::STATUS_W-1:0]    status_o,
  output logic [fqow_pkg::REQ_W-1:0]       recipient_o,
  output logic [fqow_pkg::PAYLOAD_W-1:0]   out_data_o,
  output logic [fqow_pkg::PAYLOAD_W-1:0]   visit_total_o
);

  localparam int unsigned IAW = $clog2(ITEM_DEPTH);
  localparam int unsigned ICW = $clog2(ITEM_DEPTH + 1);
  localparam int unsigned WAW = $clog2(WAITER_DEPTH);
  localparam int unsigned WCW = $clog2(WAITER_DEPTH + 1);
  localparam int unsigned PW  = fqow_pkg::PAYLOAD_W;
  localparam int unsigned RW  = fqow_pkg::REQ_W;

  // Latched request.
  logic [fqow_pkg::KIND_W-1:0] kind_q;
  logic [RW-1:0]               req_q;
  logic [DATA_WIDTH-1:0]       data_q;
  logic [63:0]                 data_wide;

  // Ring buffer pointers and counters.
  logic [IAW-1:0] ihead_q, ihead_d;
  logic [ICW-1:0] icount_q, icount_d;
  logic [WAW-1:0] whead_q, whead_d;
  logic [WCW-1:0] wcount_q, wcount_d;
  logic [PW-1:0]  visit_q, visit_d;

  // Memories with registered read at the head entry.
  logic [DATA_WIDTH-1:0] istore [ITEM_DEPTH];
  logic [RW-1:0]         wstore [WAITER_DEPTH];
  logic [DATA_WIDTH-1:0] ird_q;
  logic [RW-1:0]         wrd_q;

  logic           iwe, wwe;
  logic [ICW:0]   isum, itail;
  logic [WCW:0]   wsum, wtail;
  logic [IAW-1:0] iwaddr, ihead_inc;
  logic [WAW-1:0] wwaddr, whead_inc;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic                        load_out;
  logic [fqow_pkg::STATUS_W-1:0] status_q, status_d;
  logic [RW-1:0]               recip_q, recip_d;
  logic [PW-1:0]               odata_q, odata_d;
  logic [PW-1:0]               ovisit_q;
  logic [DATA_WIDTH-1:0]       deliv_data;
  logic [63:0]                 deliv_wide;

  assign data_wide = 64'(item_data_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_i;
      req_q  <= requester_i;
      data_q <= data_wide[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (iwe) istore[iwaddr] <= data_q;
    if (wwe) wstore[wwaddr] <= req_q;
    ird_q <= istore[ihead_q];
    wrd_q <= wstore[whead_q];
  end

  // Tail addresses: head plus count, wrapped with one compare and subtract.
  assign isum  = (ICW+1)'(ihead_q) + (ICW+1)'(icount_q);
  assign itail = (isum >= (ICW+1)'(ITEM_DEPTH)) ? isum - (ICW+1)'(ITEM_DEPTH) : isum;
  assign iwaddr = itail[IAW-1:0];
  assign wsum  = (WCW+1)'(whead_q) + (WCW+1)'(wcount_q);
  assign wtail = (wsum >= (WCW+1)'(WAITER_DEPTH)) ? wsum - (WCW+1)'(WAITER_DEPTH) : wsum;
  assign wwaddr = wtail[WAW-1:0];

  assign ihead_inc = (ihead_q == IAW'(ITEM_DEPTH - 1)) ? '0 : ihead_q + IAW'(1);
  assign whead_inc = (whead_q == WAW'(WAITER_DEPTH - 1)) ? '0 : whead_q + WAW'(1);

  always_comb begin
    ihead_d    = ihead_q;
    icount_d   = icount_q;
    whead_d    = whead_q;
    wcount_d   = wcount_q;
    visit_d    = visit_q;
    iwe        = 1'b0;
    wwe        = 1'b0;
    load_out   = 1'b0;
    status_d   = fqow_pkg::ST_EMPTY;
    recip_d    = '0;
    deliv_data = '0;
    if (cmd_i.exec) begin
      case (kind_q)
        fqow_pkg::KIND_ENQ: begin
          load_out = 1'b1;
          if (wcount_q != '0) begin
            // Hand the item straight to the oldest waiter.
            whead_d    = whead_inc;
            wcount_d   = wcount_q - WCW'(1);
            visit_d    = visit_q + PW'(1);
            status_d   = fqow_pkg::ST_DELIVERED;
            recip_d    = wrd_q;
            deliv_data = data_q;
          end else if (icount_q < ICW'(ITEM_DEPTH)) begin
            iwe      = 1'b1;
            icount_d = icount_q + ICW'(1);
            status_d = fqow_pkg::ST_STORED;
          end else begin
            status_d = fqow_pkg::ST_ITEM_OVF;
          end
        end
        fqow_pkg::KIND_DEQ, fqow_pkg::KIND_TRY: begin
          load_out = 1'b1;
          if (icount_q != '0) begin
            ihead_d    = ihead_inc;
            icount_d   = icount_q - ICW'(1);
            visit_d    = visit_q + PW'(1);
            status_d   = fqow_pkg::ST_DELIVERED;
            recip_d    = req_q;
            deliv_data = ird_q;
          end else if (kind_q == fqow_pkg::KIND_TRY) begin
            status_d = fqow_pkg::ST_EMPTY;
          end else if (wcount_q < WCW'(WAITER_DEPTH)) begin
            wwe      = 1'b1;
            wcount_d = wcount_q + WCW'(1);
            status_d = fqow_pkg::ST_WAITING;
          end else begin
            status_d = fqow_pkg::ST_WAIT_OVF;
          end
        end
        default: begin
          // The unused kind changes nothing and gives no beat.
          load_out = 1'b0;
        end
      endcase
    end
  end

  assign deliv_wide = 64'(deliv_data);
  assign odata_d    = deliv_wide[PW-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ihead_q     <= '0;
      icount_q    <= '0;
      whead_q     <= '0;
      wcount_q    <= '0;
      visit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ihead_q     <= ihead_d;
      icount_q    <= icount_d;
      whead_q     <= whead_d;
      wcount_q    <= wcount_d;
      visit_q     <= visit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= status_d;
      recip_q  <= recip_d;
      odata_q  <= odata_d;
      ovisit_q <= visit_d;
    end
  end

  assign sts_o.out_blocked  = out_valid_q && !out_ready_i;
  assign sts_o.items_pend   = (icount_q != '0);
  assign sts_o.waiters_pend = (wcount_q != '0);

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign recipient_o   = recip_q;
  assign out_data_o    = odata_q;
  assign visit_total_o = ovisit_q;

endmodule

// File: sv/fifo_queue_with_ordered_waiters.sv
// Top level of the item queue with an ordered queue of waiting requesters.
//
//   channel  dir  fields                                      accepted when
//   req_i    in   kind, requester, item_data                  valid && ready
//   rsp_o    out  status, recipient, out_data, visit_total    valid && ready
//
// Each request has an accept beat, then an execute state that uses the
// head entries read out of the item and waiter memories at the accept edge.
// The execute cycle waits while the output register still holds an untaken beat; the next
// request is accepted as soon as execution finishes, so at most one result is held.
// Reset clears pointers, counts and the visit counter at once; the memories need no pass.
// A request of the unused kind is executed without producing a response beat.
`include "assert_macros.svh"

module fifo_queue_with_ordered_waiters #(
  parameter int unsigned ITEM_DEPTH   = 16,
  parameter int unsigned WAITER_DEPTH = 16,
  parameter int unsigned DATA_WIDTH   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqow_req_if.sink   req_i,
  fqow_rsp_if.source rsp_o
);

  fqow_pkg::cmd_t cmd;
  fqow_pkg::sts_t sts;

  fqow_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fqow_dp #(
    .ITEM_DEPTH   (ITEM_DEPTH),
    .WAITER_DEPTH (WAITER_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (req_i.kind),
    .requester_i   (req_i.requester),
    .item_data_i   (req_i.item_data),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .recipient_o   (rsp_o.recipient),
    .out_data_o    (rsp_o.out_data),
    .visit_total_o (rsp_o.visit_total)
  );

  // Stored items and recorded waiters are never pending together.
  `ASSERT_NEVER(a_not_both_pending, sts.items_pend && sts.waiters_pend, "items and waiters both pending")
  // A response beat only appears after an execute cycle.
  `ASSERT_CLK(a_rsp_after_exec, $rose(rsp_o.valid) |-> $past(cmd.exec), "response without execute")
  // Only one request is in flight at a time.
  `ASSERT_CLK(a_one_in_flight, (req_i.valid && req_i.ready) |=> !req_i.ready, "second request taken early")

endmodule

// File: tb/fifo_queue_with_ordered_waiters_test.sv
// Self-checking testbench for the item queue with ordered waiting requesters.
module fifo_queue_with_ordered_waiters_test;

  localparam int unsigned ITEM_DEPTH    = 16;
  localparam int unsigned WAITER_DEPTH  = 16;
  localparam int unsigned DATA_WIDTH    = 32;
  localparam int unsigned NUM_DIRECTED  = 19;
  localparam int unsigned RANDOM_ITEMS  = 1630;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_REPORTS   = 10;

  // The fourth encoding of the kind field is not an operation.
  localparam logic [fqow_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [fqow_pkg::STATUS_W-1:0]  status;
    logic [fqow_pkg::REQ_W-1:0]     recipient;
    logic [fqow_pkg::PAYLOAD_W-1:0] out_data;
    logic [fqow_pkg::PAYLOAD_W-1:0] visit_total;
  } outcome_t;

  typedef struct packed {
    logic [fqow_pkg::KIND_W-1:0]    kind;
    logic [fqow_pkg::REQ_W-1:0]     requester;
    logic [fqow_pkg::PAYLOAD_W-1:0] item_data;
    logic                           pinned;
    outcome_t                       answer;
  } request_t;

  typedef enum int {
    BURST_FILL,
    BURST_PARK,
    BURST_DRAIN,
    BURST_MIXED,
    BURST_NOISY
  } burst_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  fqow_req_if req_if ();
  fqow_rsp_if rsp_if ();

  fifo_queue_with_ordered_waiters #(
    .ITEM_DEPTH  (ITEM_DEPTH),
    .WAITER_DEPTH(WAITER_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the queue contents, kept by the scoreboard.
  logic [fqow_pkg::PAYLOAD_W-1:0] held_items[$];
  logic [fqow_pkg::REQ_W-1:0]     parked_ids[$];
  logic [fqow_pkg::PAYLOAD_W-1:0] handoff_count;
  outcome_t                       pending_outcomes[$];

  // Travels with each request beat so that rows with a known answer are checked against it.
  logic     pinned_valid;
  outcome_t pinned_outcome;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned mismatch_count;
  int unsigned stall_cycles;

  request_t directed_rows [NUM_DIRECTED] = '{
    '{fqow_pkg::KIND_TRY, 4'd0,  32'h0000_0000, 1'b1,
      '{fqow_pkg::ST_EMPTY,     4'd0,  32'h0000_0000, 32'd0}},
    '{fqow_pkg::KIND_DEQ, 4'd15, 32'h0000_0000, 1'b1,
      '{fqow_pkg::ST_WAITING,   4'd0,  32'h0000_0000, 32'd0}},
    '{fqow_pkg::KIND_ENQ, 4'd0,  32'hFFFF_FFFF, 1'b1,
      '{fqow_pkg::ST_DELIVERED, 4'd15, 32'hFFFF_FFFF, 32'd1}},
    '{fqow_pkg::KIND_TRY, 4'd15, 32'h0000_0000, 1'b1,
      '{fqow_pkg::ST_EMPTY,     4'd0,  32'h0000_0000, 32'd1}},
    '{KIND_UNUSED,        4'd15, 32'hFFFF_FFFF, 1'b0, '0},
    '{fqow_pkg::KIND_ENQ, 4'd15, 32'h0000_0000, 1'b1,
      '{fqow_pkg::ST_STORED,    4'd0,  32'h0000_0000, 32'd1}},
    '{fqow_pkg::KIND_ENQ, 4'd0,  32'h8000_0001, 1'b1,
      '{fqow_pkg::ST_STORED,    4'd0,  32'h0000_0000, 32'd1}},
    '{fqow_pkg::KIND_DEQ, 4'd0,  32'h0000_0000, 1'b1,
      '{fqow_pkg::ST_DELIVERED, 4'd0,  32'h0000_0000, 32'd2}},
    '{fqow_pkg::KIND_TRY, 4'd15, 32'h0000_0000, 1'b1,
      '{fqow_pkg::ST_DELIVERED, 4'd15, 32'h8000_0001, 32'd3}},
    '{fqow_pkg::KIND_DEQ, 4'd5,  32'h1234_5678, 1'b0, '0},
    '{fqow_pkg::KIND_DEQ, 4'd10, 32'h0000_0000, 1'b0, '0},
    '{fqow_pkg::KIND_ENQ, 4'd7,  32'h5A5A_5A5A, 1'b0, '0},
    '{fqow_pkg::KIND_ENQ, 4'd8,  32'hA5A5_A5A5, 1'b0, '0},
    '{fqow_pkg::KIND_ENQ, 4'd0,  32'h0000_FFFF, 1'b0, '0},
    '{fqow_pkg::KIND_ENQ, 4'd0,  32'hFFFF_0000, 1'b0, '0},
    '{KIND_UNUSED,        4'd0,  32'h0000_0000, 1'b0, '0},
    '{fqow_pkg::KIND_DEQ, 4'd3,  32'h0000_0000, 1'b0, '0},
    '{fqow_pkg::KIND_DEQ, 4'd12, 32'hFFFF_FFFF, 1'b0, '0},
    '{fqow_pkg::KIND_TRY, 4'd6,  32'h0000_0000, 1'b0, '0}
  };

  // Applies one request to the mirror; returns zero when the request yields no beat.
  function automatic bit apply_request(input logic [fqow_pkg::KIND_W-1:0] op,
                                       input logic [fqow_pkg::REQ_W-1:0] who,
                                       input logic [fqow_pkg::PAYLOAD_W-1:0] value,
                                       output outcome_t res);
    res = '0;
    case (op)
      fqow_pkg::KIND_ENQ: begin
        if (parked_ids.size() != 0) begin
          res.status    = fqow_pkg::ST_DELIVERED;
          res.recipient = parked_ids.pop_front();
          res.out_data  = value;
          handoff_count = handoff_count + fqow_pkg::PAYLOAD_W'(1);
        end else if (held_items.size() < ITEM_DEPTH) begin
          held_items.push_back(value);
          res.status = fqow_pkg::ST_STORED;
        end else begin
          res.status = fqow_pkg::ST_ITEM_OVF;
        end
      end
      fqow_pkg::KIND_DEQ, fqow_pkg::KIND_TRY: begin
        if (held_items.size() != 0) begin
          res.status    = fqow_pkg::ST_DELIVERED;
          res.recipient = who;
          res.out_data  = held_items.pop_front();
          handoff_count = handoff_count + fqow_pkg::PAYLOAD_W'(1);
        end else if (op == fqow_pkg::KIND_TRY) begin
          res.status = fqow_pkg::ST_EMPTY;
        end else if (parked_ids.size() < WAITER_DEPTH) begin
          parked_ids.push_back(who);
          res.status = fqow_pkg::ST_WAITING;
        end else begin
          res.status = fqow_pkg::ST_WAIT_OVF;
        end
      end
      default: return 1'b0;
    endcase
    res.visit_total = handoff_count;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [fqow_pkg::PAYLOAD_W-1:0] want,
                               input logic [fqow_pkg::PAYLOAD_W-1:0] seen);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, seen);
    end
  endtask

  // Scoreboard: check the response beat first, then predict from the request beat.
  always @(posedge clk_i) begin
    outcome_t seen;
    outcome_t want;
    outcome_t guess;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen = '{rsp_if.status, rsp_if.recipient, rsp_if.out_data, rsp_if.visit_total};
        if (pending_outcomes.size() == 0) begin
          flag_mismatch("status of a beat with nothing expected", '0,
                        fqow_pkg::PAYLOAD_W'(seen.status));
        end else begin
          want = pending_outcomes.pop_front();
          if (seen.status !== want.status) begin
            flag_mismatch("status", fqow_pkg::PAYLOAD_W'(want.status),
                          fqow_pkg::PAYLOAD_W'(seen.status));
          end
          if (seen.recipient !== want.recipient) begin
            flag_mismatch("recipient", fqow_pkg::PAYLOAD_W'(want.recipient),
                          fqow_pkg::PAYLOAD_W'(seen.recipient));
          end
          if (seen.out_data !== want.out_data) begin
            flag_mismatch("out_data", want.out_data, seen.out_data);
          end
          if (seen.visit_total !== want.visit_total) begin
            flag_mismatch("visit_total", want.visit_total, seen.visit_total);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        if (apply_request(req_if.kind, req_if.requester, req_if.item_data, guess)) begin
          pending_outcomes.push_back(pinned_valid ? pinned_outcome : guess);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("fifo_queue_with_ordered_waiters verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one request, after an optional random gap, and returns at its accept edge.
  task automatic send_request(input request_t row);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    req_if.valid     <= 1'b1;
    req_if.kind      <= row.kind;
    req_if.requester <= row.requester;
    req_if.item_data <= row.item_data;
    pinned_valid     <= row.pinned;
    pinned_outcome   <= row.answer;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
  endtask

  function automatic request_t random_request(input burst_e mode);
    request_t    row;
    int unsigned roll;
    row  = '0;
    roll = $urandom_range(99);
    case (mode)
      BURST_FILL: begin
        row.kind = (roll < 85) ? fqow_pkg::KIND_ENQ :
                   (roll < 93) ? fqow_pkg::KIND_DEQ : fqow_pkg::KIND_TRY;
      end
      BURST_PARK: begin
        row.kind = (roll < 85) ? fqow_pkg::KIND_DEQ :
                   (roll < 93) ? fqow_pkg::KIND_ENQ : fqow_pkg::KIND_TRY;
      end
      BURST_DRAIN: begin
        row.kind = (roll < 70) ? fqow_pkg::KIND_TRY :
                   (roll < 85) ? fqow_pkg::KIND_DEQ : fqow_pkg::KIND_ENQ;
      end
      BURST_MIXED: begin
        row.kind = (roll < 34) ? fqow_pkg::KIND_ENQ :
                   (roll < 67) ? fqow_pkg::KIND_DEQ : fqow_pkg::KIND_TRY;
      end
      default: begin
        row.kind = (roll < 25) ? KIND_UNUSED : (roll < 50) ? fqow_pkg::KIND_ENQ :
                   (roll < 75) ? fqow_pkg::KIND_DEQ : fqow_pkg::KIND_TRY;
      end
    endcase
    row.requester = fqow_pkg::REQ_W'($urandom_range(15));
    case ($urandom_range(7))
      0:       row.item_data = '0;
      1:       row.item_data = '1;
      default: row.item_data = $urandom;
    endcase
    return row;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst_left;
    int unsigned phase;
    burst_e      mode;
    request_t    row;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.kind      = fqow_pkg::KIND_ENQ;
    req_if.requester = '0;
    req_if.item_data = '0;
    rsp_if.ready     = 1'b0;
    pinned_valid     = 1'b0;
    pinned_outcome   = '0;
    handoff_count    = '0;
    mismatch_count   = 0;
    stall_cycles     = 0;
    tx_idle_pct      = 34;
    rx_idle_pct      = 51;
    mode             = BURST_MIXED;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Bursts that lean toward one operation drive both stores to full and past it.
    sent       = 0;
    burst_left = 0;
    phase      = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0 && sent >= RANDOM_ITEMS / 3) begin
        phase = 1;
        hold_until_drained();
        tx_idle_pct = 51;
        rx_idle_pct <= 34;
      end else if (phase == 1 && sent >= 2 * RANDOM_ITEMS / 3) begin
        phase = 2;
        hold_until_drained();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (burst_left == 0) begin
        mode       = burst_e'($urandom_range(4));
        burst_left = $urandom_range(8, 40);
      end
      row = random_request(mode);
      burst_left--;
      send_request(row);
      sent++;
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("fifo_queue_with_ordered_waiters verification clean");
    end else begin
      $display("fifo_queue_with_ordered_waiters verification failed");
    end
    $finish;
  end

endmodule
